/* hdl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSAW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSAW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSAW_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSAW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hdl/psaw_pkg.sv */
`default_nettype none
package psaw_pkg;
    localparam int NUM_ENTRIES  = 8;
    localparam int MEM_BITS     = 10;
    localparam int URGENCY_BITS = 8;
    localparam int CNT_W        = $clog2(NUM_ENTRIES);

    typedef struct packed {
        logic [7:0]              pid;
        logic [MEM_BITS-1:0]     mem;
        logic [MEM_BITS-1:0]     lim;
        logic [URGENCY_BITS-1:0] urg;
        logic [3:0]              skips;
        logic                    leaking;
        logic                    active;
        logic                    blocked;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_SORT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     sort_left;
    } t_cell_cmd;

    localparam logic [1:0] CFG_AGING_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_LEAK_STEP    = 2'd1;
    localparam logic [1:0] CFG_HEAL_VALUE   = 2'd2;
    localparam logic [1:0] CFG_DEADLOCK_MIN = 2'd3;
endpackage
`default_nettype wire

/* hdl/psaw_cell.sv */
`default_nettype none
module psaw_cell
    import psaw_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_cmd i_cmd,
    input  wire t_entry    i_load,
    input  wire t_entry    i_shift,
    input  wire t_entry    i_left,
    input  wire t_entry    i_right,
    output t_entry         o_entry
);
    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.op)
            CELL_HOLD:  n_entry = r_entry;
            CELL_LOAD:  n_entry = i_load;
            CELL_SHIFT: n_entry = i_shift;
            CELL_SORT: begin
                // strict compare keeps equal urgencies in their order
                if (i_cmd.sort_left) begin
                    if (i_right.urg > r_entry.urg) n_entry = i_right;
                end else begin
                    if (r_entry.urg > i_left.urg) n_entry = i_left;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
endmodule
`default_nettype wire

/* hdl/priority_scheduler_aging_watchdog_core.sv */
// Priority scheduler with aging and a blocked-entry watchdog. The table lives in a
// row of NUM_ENTRIES cells. A load request writes one cell. A tick request passes
// through the LEAK, SORT, SCHED and DONE states before its result is valid. One
// rotation of the row past the head unit applies leak healing and counts blocked
// entries. NUM_ENTRIES rounds of odd-even neighbor swaps re-sort by urgency. A
// second rotation releases blocked entries when the watchdog fired, grants the
// processor, ages skipped entries and sums memory. The DONE state registers the
// result, and the input reopens once the block is back in idle. The head unit sees
// one entry per cycle, which sets the tick length. If the previous result still
// waits on the output, the tick holds in DONE and the input stays closed until the
// output is taken. Loads are taken while a tick result still waits on the output.
`default_nettype none
`include "assert_macros.svh"
module priority_scheduler_aging_watchdog_core
    import psaw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // slot[2:0] pid[10:3] mem_now[20:11] mem_limit[30:21] urgency[38:31]
    // leaking[39] alive[40] blocked[41]
    input  wire logic [47:0] i_s_axis_tdata,
    // kind[0]
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // run_valid[0] run_pid[8:1] total_memory[21:9] deadlock_found[22]
    // blocked_count[26:23] victim_pid[34:27] aged_count[38:35] healed_count[42:39]
    output logic [47:0]      o_m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data
);
    typedef enum logic [2:0] {ST_IDLE, ST_LEAK, ST_SORT, ST_SCHED, ST_DONE} t_state;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_ENTRIES - 1);
    localparam logic [MEM_BITS-1:0] MEM_MAX = '1;
    localparam logic [URGENCY_BITS-1:0] URG_MAX = '1;

    t_state r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [3:0] r_aging, r_dl_min;
    logic [7:0] r_leak_step;
    logic [9:0] r_heal;
    logic [3:0] r_healed, r_blk, r_aged;
    logic r_have;
    logic [URGENCY_BITS-1:0] r_best;
    logic [7:0] r_victim, r_run_pid;
    logic r_run;
    logic [12:0] r_total;
    logic r_out_valid;
    logic [47:0] r_out;

    t_entry w_ent [NUM_ENTRIES];
    t_cell_cmd w_cmd [NUM_ENTRIES];
    t_entry w_load, w_head;
    logic w_accept, w_found, w_emit;
    logic w_heal_hit, w_blk_hit, w_victim_hit, w_run_hit, w_age_hit;
    logic [15:0] w_heal16;
    logic [16:0] w_sum;
    logic [3:0] w_skips;
    logic [17:0] w_tot;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign w_found = (r_blk >= r_dl_min);
    assign w_heal16 = 16'(r_heal);
    assign w_emit = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        w_load.pid     = i_s_axis_tdata[10:3];
        w_load.mem     = MEM_BITS'({6'd0, i_s_axis_tdata[20:11]});
        w_load.lim     = MEM_BITS'({6'd0, i_s_axis_tdata[30:21]});
        w_load.urg     = URGENCY_BITS'({8'd0, i_s_axis_tdata[38:31]});
        w_load.skips   = 4'd0;
        w_load.leaking = i_s_axis_tdata[39];
        w_load.active  = i_s_axis_tdata[40];
        w_load.blocked = i_s_axis_tdata[41];
    end

    // head unit: works on the entry at cell 0 during both rotations
    always_comb begin
        w_head = w_ent[0];
        w_heal_hit = 1'b0;
        w_run_hit = 1'b0;
        w_age_hit = 1'b0;
        w_sum = 17'(w_ent[0].mem) + 17'(r_leak_step);
        if (w_sum > 17'(MEM_MAX)) w_sum = 17'(MEM_MAX);
        w_skips = (w_ent[0].skips == 4'd15) ? 4'd15 : w_ent[0].skips + 4'd1;
        w_blk_hit = w_ent[0].active && w_ent[0].blocked;
        w_victim_hit = w_blk_hit && (!r_have || w_ent[0].urg < r_best);
        if (r_state == ST_LEAK) begin
            if (w_ent[0].active && !w_ent[0].blocked && w_ent[0].leaking) begin
                w_head.mem = w_sum[MEM_BITS-1:0];
                if (w_sum[MEM_BITS-1:0] >= w_ent[0].lim) begin
                    w_head.mem = w_heal16[MEM_BITS-1:0];
                    w_head.leaking = 1'b0;
                    w_heal_hit = 1'b1;
                end
            end
        end else begin
            // release blocked entries when the watchdog fired
            if (w_found && w_ent[0].active) w_head.blocked = 1'b0;
            if (w_head.active && !w_head.blocked) begin
                if (!r_run) begin
                    w_run_hit = 1'b1;
                    w_head.skips = 4'd0;
                end else if (w_skips >= r_aging) begin
                    w_age_hit = 1'b1;
                    w_head.skips = 4'd0;
                    if (w_ent[0].urg != URG_MAX) w_head.urg = w_ent[0].urg + 1'b1;
                end else begin
                    w_head.skips = w_skips;
                end
            end
        end
        w_tot = 18'(r_total) + (w_ent[0].active ? 18'(w_ent[0].mem) : 18'd0);
        if (w_tot > 18'd8191) w_tot = 18'd8191;
    end

    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            w_cmd[i].op = CELL_HOLD;
            w_cmd[i].sort_left = 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && !i_s_axis_tuser && (int'(i_s_axis_tdata[2:0]) == i))
                        w_cmd[i].op = CELL_LOAD;
                end
                ST_LEAK, ST_SCHED: w_cmd[i].op = CELL_SHIFT;
                ST_SORT: begin
                    if ((i % 2) == int'(r_cnt[0]) && (i + 1) < NUM_ENTRIES) begin
                        w_cmd[i].op = CELL_SORT;
                        w_cmd[i].sort_left = 1'b1;
                    end else if (i >= 1 && ((i + 1) % 2) == int'(r_cnt[0])) begin
                        w_cmd[i].op = CELL_SORT;
                    end
                end
                ST_DONE: w_cmd[i].op = CELL_HOLD;
                default: w_cmd[i].op = CELL_HOLD;
            endcase
        end
    end

    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
        psaw_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd[g]),
            .i_load  (w_load),
            .i_shift ((g == NUM_ENTRIES - 1) ? w_head : w_ent[(g + 1) % NUM_ENTRIES]),
            .i_left  (w_ent[(g + NUM_ENTRIES - 1) % NUM_ENTRIES]),
            .i_right (w_ent[(g + 1) % NUM_ENTRIES]),
            .o_entry (w_ent[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_aging     <= 4'd3;
            r_leak_step <= 8'd12;
            r_heal      <= 10'd10;
            r_dl_min    <= 4'd2;
            r_out_valid <= 1'b0;
            r_out       <= '0;
            r_healed <= '0; r_blk <= '0; r_aged <= '0; r_have <= 1'b0;
            r_best <= '0; r_victim <= '0; r_run <= 1'b0; r_run_pid <= '0;
            r_total <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_AGING_LIMIT:  r_aging     <= i_cfg_data[3:0];
                    CFG_LEAK_STEP:    r_leak_step <= i_cfg_data[7:0];
                    CFG_HEAL_VALUE:   r_heal      <= i_cfg_data;
                    CFG_DEADLOCK_MIN: r_dl_min    <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (w_emit) r_out_valid <= 1'b1;
            else if (r_out_valid && i_m_axis_tready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && i_s_axis_tuser) begin
                        r_state <= ST_LEAK;
                        r_cnt <= '0;
                        r_healed <= '0; r_blk <= '0; r_aged <= '0; r_have <= 1'b0;
                        r_best <= '0; r_victim <= '0; r_run <= 1'b0;
                        r_run_pid <= '0; r_total <= '0;
                    end
                end
                ST_LEAK: begin
                    if (w_heal_hit && r_healed != 4'd15) r_healed <= r_healed + 4'd1;
                    if (w_blk_hit && r_blk != 4'd15) r_blk <= r_blk + 4'd1;
                    if (w_victim_hit) begin
                        r_have <= 1'b1;
                        r_best <= w_ent[0].urg;
                        r_victim <= w_ent[0].pid;
                    end
                    if (r_cnt == CNT_LAST) begin
                        r_cnt <= '0;
                        r_state <= ST_SORT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SORT: begin
                    if (r_cnt == CNT_LAST) begin
                        r_cnt <= '0;
                        r_state <= ST_SCHED;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SCHED: begin
                    if (w_run_hit) begin
                        r_run <= 1'b1;
                        r_run_pid <= w_ent[0].pid;
                    end
                    if (w_age_hit && r_aged != 4'd15) r_aged <= r_aged + 4'd1;
                    r_total <= w_tot[12:0];
                    if (r_cnt == CNT_LAST) begin
                        r_cnt <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (w_emit) begin
                        r_out <= {5'd0, r_healed, r_aged, (w_found ? r_victim : 8'd0),
                                  r_blk, w_found, r_total, r_run_pid, r_run};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    `PSAW_ASSERT(a_busy_not_ready, i_clk, i_rst_n, (r_state != ST_IDLE) |-> !o_s_axis_tready, "ready while busy")
    `PSAW_ASSERT(a_idle_pid, i_clk, i_rst_n, (o_m_axis_tvalid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata[8:1] == 8'd0), "idle result with pid")
    `PSAW_ASSERT(a_tick_len, i_clk, i_rst_n, (w_accept && i_s_axis_tuser) |=> (r_state == ST_LEAK), "tick did not start")
endmodule
`default_nettype wire

/* tb/priority_scheduler_aging_watchdog_core_tb.sv */
`default_nettype none
module priority_scheduler_aging_watchdog_core_tb;
    import psaw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 6000;
    localparam int DRAIN_WAIT  = 40;
    localparam int TICK_CYCLES = 3 * NUM_ENTRIES + 1;

    typedef struct {
        bit       is_tick;
        bit [2:0] slot;
        bit [7:0] pid;
        bit [9:0] mem;
        bit [9:0] lim;
        bit [7:0] urg;
        bit       leaking;
        bit       alive;
        bit       blocked;
    } sched_request_t;

    typedef struct {
        bit        run_valid;
        bit [7:0]  run_pid;
        bit [12:0] total_memory;
        bit        deadlock_found;
        bit [3:0]  blocked_count;
        bit [7:0]  victim_pid;
        bit [3:0]  aged_count;
        bit [3:0]  healed_count;
    } tick_report_t;

    typedef struct {
        bit [7:0] pid;
        bit [9:0] mem;
        bit [9:0] lim;
        bit [7:0] urg;
        bit [3:0] skips;
        bit       leaking;
        bit       active;
        bit       blocked;
    } proc_slot_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data = '0;

    priority_scheduler_aging_watchdog_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scheduler state as the block should hold it
    proc_slot_t   proc_table [NUM_ENTRIES];
    bit [3:0]     aging_limit_r, deadlock_min_r;
    bit [7:0]     leak_step_r;
    bit [9:0]     heal_value_r;

    sched_request_t pending_requests[$];
    tick_report_t   expected_reports[$];
    int  mismatches = 0;
    int  ticks_sent = 0, loads_sent = 0, reports_seen = 0, deadlocks_seen = 0, heals_seen = 0;
    bit  idle_off = 1'b0;
    bit  hold_start = 1'b0;
    int  hold_left = 0;
    int  idle_cycles = 0;

    function automatic void reset_scheduler();
        foreach (proc_table[i]) proc_table[i] = '{default: 0};
        aging_limit_r  = 4'd3;
        leak_step_r    = 8'd12;
        heal_value_r   = 10'd10;
        deadlock_min_r = 4'd2;
    endfunction

    function automatic void add_request(sched_request_t q);
        pending_requests.insert(pending_requests.size(), q);
    endfunction

    function automatic tick_report_t schedule_tick();
        tick_report_t r;
        proc_slot_t   cur;
        int           j, total, nblk, naged, nheal;
        bit           have;
        bit [7:0]     best;
        bit [4:0]     s;
        bit [10:0]    m;
        r = '{default: 0};
        total = 0; nblk = 0; naged = 0; nheal = 0; have = 0; best = 0;
        // leak growth, heal once the limit is reached
        foreach (proc_table[i]) begin
            if (proc_table[i].active && !proc_table[i].blocked && proc_table[i].leaking) begin
                m = 11'(proc_table[i].mem) + 11'(leak_step_r);
                if (m > 11'd1023) m = 11'd1023;
                if (m >= 11'(proc_table[i].lim)) begin
                    m = 11'(heal_value_r);
                    proc_table[i].leaking = 0;
                    nheal++;
                end
                proc_table[i].mem = m[9:0];
            end
        end
        foreach (proc_table[i])
            if (proc_table[i].active && proc_table[i].blocked) nblk++;
        if (nblk >= int'(deadlock_min_r)) begin
            r.deadlock_found = 1;
            foreach (proc_table[i]) begin
                if (proc_table[i].active && proc_table[i].blocked &&
                    (!have || proc_table[i].urg < best)) begin
                    have = 1;
                    best = proc_table[i].urg;
                    r.victim_pid = proc_table[i].pid;
                end
            end
            foreach (proc_table[i])
                if (proc_table[i].active) proc_table[i].blocked = 0;
        end
        // stable insertion sort, highest urgency first
        for (int i = 1; i < NUM_ENTRIES; i++) begin
            cur = proc_table[i];
            j = i;
            while (j > 0 && cur.urg > proc_table[j-1].urg) begin
                proc_table[j] = proc_table[j-1];
                j--;
            end
            proc_table[j] = cur;
        end
        foreach (proc_table[i]) begin
            if (proc_table[i].active && !proc_table[i].blocked) begin
                if (!r.run_valid) begin
                    r.run_valid = 1;
                    r.run_pid = proc_table[i].pid;
                    proc_table[i].skips = 0;
                end else begin
                    s = 5'(proc_table[i].skips) + 5'd1;
                    if (s > 5'd15) s = 5'd15;
                    if (s >= 5'(aging_limit_r)) begin
                        if (proc_table[i].urg != 8'hFF) proc_table[i].urg++;
                        s = 5'd0;
                        naged++;
                    end
                    proc_table[i].skips = s[3:0];
                end
            end
        end
        foreach (proc_table[i])
            if (proc_table[i].active) total += proc_table[i].mem;
        r.total_memory  = (total > 8191) ? 13'd8191 : total[12:0];
        r.blocked_count = (nblk > 15) ? 4'd15 : nblk[3:0];
        r.aged_count    = (naged > 15) ? 4'd15 : naged[3:0];
        r.healed_count  = (nheal > 15) ? 4'd15 : nheal[3:0];
        return r;
    endfunction

    function automatic void apply_request(sched_request_t q);
        if (q.is_tick) begin
            expected_reports.insert(expected_reports.size(), schedule_tick());
            ticks_sent++;
        end else begin
            proc_table[q.slot] = '{pid: q.pid, mem: q.mem, lim: q.lim, urg: q.urg, skips: 0,
                                   leaking: q.leaking, active: q.alive, blocked: q.blocked};
            loads_sent++;
        end
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_off || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // request driver
    sched_request_t cur_req;
    int             send_gap = 0;
    always @(posedge i_clk) begin
        bit nv;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            nv = 1'b1;
            if (i_s_axis_tvalid && o_s_axis_tready) apply_request(cur_req);
            if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    nv = 1'b0;
                end else if (pending_requests.size() > 0) begin
                    cur_req = pending_requests[0];
                    pending_requests.delete(0);
                    send_gap = draw_gap();
                end else begin
                    nv = 1'b0;
                end
            end
            i_s_axis_tvalid <= nv;
            i_s_axis_tuser  <= cur_req.is_tick;
            i_s_axis_tdata  <= {6'b0, cur_req.blocked, cur_req.alive, cur_req.leaking,
                                cur_req.urg, cur_req.lim, cur_req.mem, cur_req.pid, cur_req.slot};
        end
    end

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on report %0d: %s got %0d expected %0d", reports_seen, field, got, want);
        mismatches++;
    endtask

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_start) hold_left <= 400;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // report monitor
    int stall_left = 0;
    always @(posedge i_clk) begin
        tick_report_t w;
        bit [47:0]    d;
        int           r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            d = o_m_axis_tdata;
            if (expected_reports.size() == 0) begin
                $display("unexpected report, data %h", d);
                mismatches++;
            end else begin
                w = expected_reports[0];
                expected_reports.delete(0);
                if (d[0] != w.run_valid) report_mismatch("run_valid", d[0], w.run_valid);
                if (d[8:1] != w.run_pid) report_mismatch("run_pid", d[8:1], w.run_pid);
                if (d[21:9] != w.total_memory)
                    report_mismatch("total_memory", d[21:9], w.total_memory);
                if (d[22] != w.deadlock_found)
                    report_mismatch("deadlock_found", d[22], w.deadlock_found);
                if (d[26:23] != w.blocked_count)
                    report_mismatch("blocked_count", d[26:23], w.blocked_count);
                if (d[34:27] != w.victim_pid) report_mismatch("victim_pid", d[34:27], w.victim_pid);
                if (d[38:35] != w.aged_count) report_mismatch("aged_count", d[38:35], w.aged_count);
                if (d[42:39] != w.healed_count)
                    report_mismatch("healed_count", d[42:39], w.healed_count);
                if (w.deadlock_found) deadlocks_seen++;
                if (w.healed_count != 0) heals_seen++;
            end
            reports_seen++;
        end
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (!idle_off && r < 8) stall_left = $urandom_range(1, 4);
            else if (!idle_off && r < 10) stall_left = $urandom_range(15, 50);
            i_m_axis_tready <= (stall_left == 0);
        end
    end

    // stop if nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(logic [1:0] idx, logic [9:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_AGING_LIMIT:  aging_limit_r  = val[3:0];
            CFG_LEAK_STEP:    leak_step_r    = val[7:0];
            CFG_HEAL_VALUE:   heal_value_r   = val;
            CFG_DEADLOCK_MIN: deadlock_min_r = val[3:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        wait (pending_requests.size() == 0 && !i_s_axis_tvalid && expected_reports.size() == 0);
        repeat (TICK_CYCLES + DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_regs(int al, int ls, int hv, int dm);
        write_reg(CFG_AGING_LIMIT, 10'(al));
        write_reg(CFG_LEAK_STEP, 10'(ls));
        write_reg(CFG_HEAL_VALUE, 10'(hv));
        write_reg(CFG_DEADLOCK_MIN, 10'(dm));
    endtask

    function automatic sched_request_t make_load(int slot, int pid, int mem, int lim, int urg,
                                                 bit lk, bit al, bit bl);
        sched_request_t q;
        q = '{is_tick: 0, slot: 3'(slot), pid: 8'(pid), mem: 10'(mem), lim: 10'(lim),
              urg: 8'(urg), leaking: lk, alive: al, blocked: bl};
        return q;
    endfunction

    function automatic int pick10();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 1023;
        return $urandom_range(0, 1023);
    endfunction

    function automatic sched_request_t random_request(int tick_pct);
        sched_request_t q;
        int u;
        u = $urandom_range(0, 9);
        q = make_load($urandom_range(0, 7), $urandom_range(0, 255), pick10(), pick10(),
                      (u == 0) ? 255 : (u == 1) ? 0 : (u < 6) ? $urandom_range(0, 7)
                                                              : $urandom_range(0, 255),
                      $urandom_range(0, 1), $urandom_range(0, 3) != 0,
                      $urandom_range(0, 2) == 0);
        q.is_tick = ($urandom_range(0, 99) < tick_pct);
        // loads carry junk slot/fields on ticks too, the block must ignore them
        return q;
    endfunction

    task automatic random_phase(int n, int tick_pct);
        for (int i = 0; i < n; i++) add_request(random_request(tick_pct));
        settle();
    endtask

    initial begin
        sched_request_t tk;
        reset_scheduler();
        tk = make_load(0, 0, 0, 0, 0, 0, 0, 0);
        tk.is_tick = 1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, field extremes, deadlock, heal, saturation
        add_request(tk);
        add_request(make_load(7, 255, 1023, 1023, 255, 1, 1, 0));
        add_request(make_load(0, 0, 0, 0, 0, 1, 1, 0));
        add_request(make_load(3, 17, 500, 1000, 255, 0, 1, 1));
        add_request(make_load(4, 18, 200, 0, 3, 0, 1, 1));
        add_request(make_load(5, 19, 100, 0, 3, 0, 1, 1));
        add_request(make_load(6, 20, 1023, 0, 9, 1, 0, 1));
        add_request(tk);
        add_request(tk);
        add_request(make_load(1, 99, 1020, 1023, 1, 1, 1, 0));
        add_request(make_load(2, 98, 1015, 1023, 1, 1, 1, 0));
        for (int i = 0; i < 6; i++) add_request(tk);
        settle();

        set_regs(1, 255, 0, 1);
        add_request(make_load(2, 42, 5, 6, 254, 1, 1, 1));
        for (int i = 0; i < 4; i++) add_request(tk);
        settle();

        // fill the block while the receiver holds off
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        random_phase(400, 40);

        set_regs(15, 0, 1023, 8);
        random_phase(400, 35);

        set_regs(0, 7, 1, 0);
        random_phase(350, 40);

        set_regs(2, 30, 512, 3);
        idle_off = 1'b1;
        random_phase(150, 40);
        idle_off = 1'b0;

        set_regs($urandom_range(1, 15), $urandom_range(0, 255), $urandom_range(0, 1023),
                 $urandom_range(1, 8));
        random_phase(400, 40);

        $display("sent %0d loads and %0d ticks over six register settings",
                 loads_sent, ticks_sent);
        $display("checked %0d reports, %0d with a deadlock release, %0d with healing",
                 reports_seen, deadlocks_seen, heals_seen);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/psaw_pkg.sv
hdl/psaw_cell.sv
hdl/priority_scheduler_aging_watchdog_core.sv
tb/priority_scheduler_aging_watchdog_core_tb.sv
